// ===== hdl/best_fit_segment_allocator_assert.svh =====
// Assertion helpers used by the allocator datapath (bfsa_dp).
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BFSA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BFSA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bfsa_pkg.sv =====
`default_nettype none

package bfsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int ID_BITS_DEF      = 16;

    localparam int SZ_W        = 9;
    localparam int BASE_W      = 8;
    localparam int LEFT_W      = 8;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 16;

    localparam logic [SZ_W-1:0] SPACE_LIMIT = 9'd256;

    localparam logic [STAT_W-1:0] ST_GRANT = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic scan_rd;
        logic set_nofit;
        logic shift_setup;
        logic shift_rd;
        logic wr_free;
        logic wr_used;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic init_busy;
        logic full;
        logic req_zero;
        logic scan_last;
        logic found;
        logic shift_more;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/bfsa_ctrl.sv =====
`default_nettype none

module bfsa_ctrl (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_tvalid,
    output logic           s_tready,
    input  bfsa_pkg::sts_t sts,
    output bfsa_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_DRAIN   = 4'd2;
    localparam logic [3:0] S_EVAL    = 4'd3;
    localparam logic [3:0] S_SHIFT   = 4'd4;
    localparam logic [3:0] S_WR_FREE = 4'd5;
    localparam logic [3:0] S_WR_USED = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = !sts.init_busy;
                if (s_tvalid && !sts.init_busy) begin
                    cmd.accept = 1'b1;
                    if (sts.full || sts.req_zero) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            // last scan read is compared in this cycle
            S_DRAIN: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (sts.found) begin
                    cmd.shift_setup = 1'b1;
                    state_next      = S_SHIFT;
                end else begin
                    cmd.set_nofit = 1'b1;
                    state_next    = S_DONE;
                end
            end
            // reads go down the table; each lands one slot higher in the next cycle
            S_SHIFT: begin
                if (sts.shift_more) begin
                    cmd.shift_rd = 1'b1;
                end else begin
                    state_next = S_WR_FREE;
                end
            end
            S_WR_FREE: begin
                cmd.wr_free = 1'b1;
                state_next  = S_WR_USED;
            end
            S_WR_USED: begin
                cmd.wr_used = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bfsa_dp.sv =====
`default_nettype none

`include "best_fit_segment_allocator_assert.svh"

module bfsa_dp #(
    parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ID_BITS      = bfsa_pkg::ID_BITS_DEF,
    localparam int IDX_W       = $clog2(MAX_SEGMENTS),
    localparam int OUT_W       = bfsa_pkg::STAT_W + ID_BITS + bfsa_pkg::BASE_W
                                 + IDX_W + bfsa_pkg::LEFT_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_we,
    input  wire  [bfsa_pkg::SZ_W-1:0]           cfg_wdata,
    input  wire  [bfsa_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  bfsa_pkg::cmd_t                      cmd,
    output bfsa_pkg::sts_t                      sts,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [OUT_TDATA_W-1:0]              m_tdata
);

    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int SZ_W   = bfsa_pkg::SZ_W;
    localparam int WORD_W = 1 + ID_BITS + SZ_W;

    localparam int F_OWN  = bfsa_pkg::STAT_W;
    localparam int F_BASE = F_OWN + ID_BITS;
    localparam int F_IDX  = F_BASE + bfsa_pkg::BASE_W;
    localparam int F_LEFT = F_IDX + IDX_W;

    // table word: {used, owner, size}
    logic [WORD_W-1:0] mem [MAX_SEGMENTS];

    logic [SZ_W-1:0]            total_reg;
    logic                       init_pend_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [ID_BITS-1:0]         owner_reg;
    logic [SZ_W-1:0]            req_reg;
    logic [bfsa_pkg::STAT_W-1:0] res_status_reg;
    logic [IDX_W-1:0]           addr_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic [WORD_W-1:0]          rd_data_reg;
    logic                       scan_vld_reg;
    logic                       shift_vld_reg;
    logic                       found_reg;
    logic [IDX_W-1:0]           best_idx_reg;
    logic [SZ_W-1:0]            best_size_reg;
    logic [ID_BITS-1:0]         best_owner_reg;
    logic [bfsa_pkg::BASE_W-1:0] best_base_reg;
    logic [SZ_W-1:0]            prefix_reg;
    logic                       m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]     m_tdata_reg;

    logic [SZ_W-1:0]            req_in;
    logic [SZ_W-1:0]            cfg_sat;
    logic [SZ_W-1:0]            rd_size;
    logic                       rd_used;
    logic [ID_BITS-1:0]         rd_owner;
    logic                       fit;
    logic [SZ_W-1:0]            leftover;
    logic [CNT_W-1:0]           cnt_m1;
    logic                       full;
    logic                       rd_en;
    logic                       we;
    logic [IDX_W-1:0]           wa;
    logic [WORD_W-1:0]          wd;
    logic [OUT_TDATA_W-1:0]     out_word;

    assign req_in   = s_tdata[SZ_W-1:0];
    assign cfg_sat  = (cfg_wdata > bfsa_pkg::SPACE_LIMIT) ? bfsa_pkg::SPACE_LIMIT : cfg_wdata;
    assign rd_size  = rd_data_reg[SZ_W-1:0];
    assign rd_owner = rd_data_reg[SZ_W +: ID_BITS];
    assign rd_used  = rd_data_reg[WORD_W-1];
    assign leftover = best_size_reg - req_reg;
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign full     = (cnt_reg == CNT_W'(MAX_SEGMENTS));
    assign rd_en    = cmd.scan_rd | cmd.shift_rd;

    // strict less-than keeps the earliest segment on ties
    assign fit = scan_vld_reg && !rd_used && (rd_size >= req_reg)
                 && (!found_reg || (rd_size < best_size_reg));

    always_comb begin
        sts            = '0;
        sts.init_busy  = init_pend_reg;
        sts.full       = full;
        sts.req_zero   = (req_in == '0);
        sts.scan_last  = (addr_reg == cnt_m1[IDX_W-1:0]);
        sts.found      = found_reg;
        sts.shift_more = (addr_reg > best_idx_reg);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    // single write port
    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        if (cfg_we || init_pend_reg) begin
            we = 1'b1;
            wd = {1'b0, {ID_BITS{1'b0}}, (cfg_we ? cfg_sat : total_reg)};
        end else if (shift_vld_reg) begin
            we = 1'b1;
            wa = rd_idx_reg + IDX_W'(1);
            wd = rd_data_reg;
        end else if (cmd.wr_free) begin
            we = 1'b1;
            wa = best_idx_reg + IDX_W'(1);
            wd = {1'b0, best_owner_reg, leftover};
        end else if (cmd.wr_used) begin
            we = 1'b1;
            wa = best_idx_reg;
            wd = {1'b1, owner_reg, req_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_comb begin
        out_word = '0;
        out_word[bfsa_pkg::STAT_W-1:0] = res_status_reg;
        if (res_status_reg == bfsa_pkg::ST_GRANT) begin
            out_word[F_OWN +: ID_BITS]           = owner_reg;
            out_word[F_BASE +: bfsa_pkg::BASE_W] = best_base_reg;
            out_word[F_IDX +: IDX_W]             = best_idx_reg;
            out_word[F_LEFT +: bfsa_pkg::LEFT_W] = leftover[bfsa_pkg::LEFT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= bfsa_pkg::SPACE_LIMIT;
            init_pend_reg <= 1'b1;
            cnt_reg       <= CNT_W'(1);
            owner_reg     <= '0;
            scan_vld_reg  <= 1'b0;
            shift_vld_reg <= 1'b0;
            found_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            init_pend_reg <= 1'b0;
            scan_vld_reg  <= cmd.scan_rd;
            shift_vld_reg <= cmd.shift_rd;
            if (cfg_we) begin
                total_reg <= cfg_sat;
                cnt_reg   <= CNT_W'(1);
            end else if (cmd.wr_used) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.accept) begin
                found_reg <= 1'b0;
            end else if (fit) begin
                found_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
                if (res_status_reg == bfsa_pkg::ST_GRANT) begin
                    owner_reg <= owner_reg + ID_BITS'(1);
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg    <= req_in;
            addr_reg   <= '0;
            prefix_reg <= '0;
            if (full) begin
                res_status_reg <= bfsa_pkg::ST_FULL;
            end else if (req_in == '0) begin
                res_status_reg <= bfsa_pkg::ST_NOFIT;
            end else begin
                res_status_reg <= bfsa_pkg::ST_GRANT;
            end
        end
        if (cmd.set_nofit) begin
            res_status_reg <= bfsa_pkg::ST_NOFIT;
        end
        if (cmd.scan_rd) begin
            addr_reg <= addr_reg + IDX_W'(1);
        end else if (cmd.shift_setup) begin
            addr_reg <= cnt_m1[IDX_W-1:0];
        end else if (cmd.shift_rd) begin
            addr_reg <= addr_reg - IDX_W'(1);
        end
        if (rd_en) begin
            rd_idx_reg <= addr_reg;
        end
        if (scan_vld_reg) begin
            prefix_reg <= prefix_reg + rd_size;
        end
        if (fit) begin
            best_idx_reg   <= rd_idx_reg;
            best_size_reg  <= rd_size;
            best_owner_reg <= rd_owner;
            best_base_reg  <= prefix_reg[bfsa_pkg::BASE_W-1:0];
        end
        if (cmd.load_out) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BFSA_ASSERT_SAME(a_cnt_range, aclk, aresetn, 1'b1,
        (cnt_reg != '0) && (cnt_reg <= CNT_W'(MAX_SEGMENTS)), "segment count out of range")
    `BFSA_ASSERT_SAME(a_shift_above_best, aclk, aresetn, shift_vld_reg,
        rd_idx_reg > best_idx_reg, "shift touched the chosen segment or below")
    `BFSA_ASSERT_SAME(a_scan_in_table, aclk, aresetn, scan_vld_reg,
        CNT_W'(rd_idx_reg) < cnt_reg, "scan read past the table end")
    `BFSA_ASSERT_SAME(a_used_needs_fit, aclk, aresetn, cmd.wr_used,
        found_reg && (res_status_reg == bfsa_pkg::ST_GRANT), "insert without a fit")
    `BFSA_ASSERT_NEXT(a_cnt_grows, aclk, aresetn, cmd.wr_used && !cfg_we,
        cnt_reg == CNT_W'($past(cnt_reg) + CNT_W'(1)), "count did not grow on insert")

endmodule

`default_nettype wire

// ===== hdl/best_fit_segment_allocator.sv =====
// Results: a full table or zero-size request skips the scan and goes straight to
//   the result; no fit scans the table, then evaluates; a grant also shifts the
//   entries above the best fit and writes two entries. One request at a time; a
//   table scan plus an insert shift through the single-port segment memory sets the pace.
// Reset (and any total_space write) restarts the table with one free segment;
//   after reset s_tready stays low while entry 0 is rewritten; a write rewrites it
//   at the same edge. Owner ids restart only on reset.
`default_nettype none

module best_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ID_BITS      = bfsa_pkg::ID_BITS_DEF,
    localparam int IDX_W       = $clog2(MAX_SEGMENTS),
    localparam int OUT_W       = bfsa_pkg::STAT_W + ID_BITS + bfsa_pkg::BASE_W
                                 + IDX_W + bfsa_pkg::LEFT_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_we,
    input  wire  [bfsa_pkg::SZ_W-1:0]       cfg_wdata,     // total_space
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [bfsa_pkg::IN_TDATA_W-1:0] s_tdata,       // request_size
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // status, owner_id, base_offset, segment_index, leftover
    output logic [OUT_TDATA_W-1:0]          m_tdata
);

    bfsa_pkg::cmd_t cmd;
    bfsa_pkg::sts_t sts;

    bfsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfsa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ID_BITS      (ID_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== sim/tb_best_fit_segment_allocator.sv =====
`timescale 1ns / 1ps

module tb_best_fit_segment_allocator;

    localparam int SLOTS      = 32;
    localparam int OUT_TDATA  = 40;
    localparam int IDLE_LIMIT = 4000;
    localparam int NUM_RANDOM = 735;

    typedef struct {
        logic [bfsa_pkg::STAT_W-1:0] status;
        logic [15:0]                 owner;
        logic [bfsa_pkg::BASE_W-1:0] base;
        logic [4:0]                  index;
        logic [bfsa_pkg::LEFT_W-1:0] left;
    } alloc_result_t;

    // Mirror of the segment table; every request yields exactly one result.
    class segment_table;
        logic [bfsa_pkg::SZ_W-1:0] seg_size [SLOTS];
        bit                        seg_used [SLOTS];
        logic [15:0]               seg_owner[SLOTS];
        int                        seg_count;
        logic [15:0]               next_owner;
        alloc_result_t             awaited[$];
        int                        errors;

        function new();
            errors     = 0;
            next_owner = '0;
            load_total(bfsa_pkg::SPACE_LIMIT);
        endfunction

        function void load_total(logic [bfsa_pkg::SZ_W-1:0] value);
            for (int i = 0; i < SLOTS; i++) begin
                seg_size[i]  = '0;
                seg_used[i]  = 1'b0;
                seg_owner[i] = '0;
            end
            seg_size[0] = (value > bfsa_pkg::SPACE_LIMIT) ? bfsa_pkg::SPACE_LIMIT : value;
            seg_count   = 1;
        endfunction

        function void note_request(logic [bfsa_pkg::SZ_W-1:0] size);
            alloc_result_t r;
            int            best;
            bit            found;
            int unsigned   base_sum;
            r     = '{default: '0};
            best  = 0;
            found = 1'b0;
            if (seg_count >= SLOTS) begin
                r.status = bfsa_pkg::ST_FULL;
            end else if (size == 0) begin
                r.status = bfsa_pkg::ST_NOFIT;
            end else begin
                for (int i = 0; i < seg_count; i++) begin
                    if (!seg_used[i] && seg_size[i] >= size &&
                        (!found || seg_size[i] < seg_size[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = bfsa_pkg::ST_NOFIT;
                end else begin
                    base_sum = 0;
                    for (int i = 0; i < best; i++)
                        base_sum += seg_size[i];
                    for (int i = seg_count; i > best; i--) begin
                        seg_size[i]  = seg_size[i-1];
                        seg_used[i]  = seg_used[i-1];
                        seg_owner[i] = seg_owner[i-1];
                    end
                    seg_count++;
                    seg_size[best]   = size;
                    seg_used[best]   = 1'b1;
                    seg_owner[best]  = next_owner;
                    seg_size[best+1] = seg_size[best+1] - size;
                    r.status = bfsa_pkg::ST_GRANT;
                    r.owner  = next_owner;
                    r.base   = base_sum[bfsa_pkg::BASE_W-1:0];
                    r.index  = best[4:0];
                    r.left   = seg_size[best+1][bfsa_pkg::LEFT_W-1:0];
                    next_owner = next_owner + 16'd1;
                end
            end
            awaited.push_back(r);
        endfunction

        function void compare(string field, int unsigned exp, int unsigned got);
            if (exp != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA-1:0] word);
            alloc_result_t e;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                errors++;
                return;
            end
            e = awaited.pop_front();
            compare("status",        e.status, word[1:0]);
            compare("owner_id",      e.owner,  word[17:2]);
            compare("base_offset",   e.base,   word[25:18]);
            compare("segment_index", e.index,  word[30:26]);
            compare("leftover",      e.left,   word[38:31]);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [bfsa_pkg::SZ_W-1:0]       cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [bfsa_pkg::IN_TDATA_W-1:0] s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [OUT_TDATA-1:0]            m_tdata;

    segment_table table_mirror = new();
    bit           calm         = 1'b0;
    int           idle_cycles  = 0;

    best_fit_segment_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 34);
    end

    // Observe handshakes on pre-edge values; the mirror moves only here.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we)
                table_mirror.load_total(cfg_wdata);
            if (s_tvalid && s_tready)
                table_mirror.note_request(s_tdata[bfsa_pkg::SZ_W-1:0]);
            if (m_tvalid && m_tready)
                table_mirror.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL best_fit_segment_allocator");
            $finish;
        end
    end

    task automatic send_request(logic [bfsa_pkg::SZ_W-1:0] size);
        if (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bfsa_pkg::IN_TDATA_W-bfsa_pkg::SZ_W){1'b0}}, size};
        do @(posedge aclk); while (!s_tready);
    endtask

    // one edge first so a request accepted at the last edge is already counted
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (table_mirror.pending() > 0) @(posedge aclk);
    endtask

    task automatic write_total(logic [bfsa_pkg::SZ_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [bfsa_pkg::SZ_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)       return '0;
        else if (roll < 12) return bfsa_pkg::SZ_W'($urandom_range(511, 257));
        else if (roll < 20) return bfsa_pkg::SZ_W'($urandom_range(256, 17));
        else if (roll < 45) return bfsa_pkg::SZ_W'($urandom_range(16, 5));
        else                return bfsa_pkg::SZ_W'($urandom_range(4, 1));
    endfunction

    function automatic logic [bfsa_pkg::SZ_W-1:0] pick_total(int phase);
        case (phase % 8)
            0:       return 9'd256;
            1:       return 9'd0;
            2:       return 9'd1;
            3:       return 9'd511;
            4:       return 9'd255;
            default: return bfsa_pkg::SZ_W'($urandom_range(511, 2));
        endcase
    endfunction

    initial begin
        int sent;
        int phase;
        int run_len;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: size extremes, zero-size, too large, zero-size leftovers
        send_request(9'd0);
        send_request(9'd511);
        send_request(9'd257);
        send_request(9'd256);
        send_request(9'd1);
        write_total(9'd0);
        send_request(9'd1);
        send_request(9'd256);
        write_total(9'd1);
        send_request(9'd1);
        send_request(9'd1);
        write_total(9'd300);
        send_request(9'd256);
        write_total(9'd200);
        send_request(9'd100);
        send_request(9'd50);
        send_request(9'd50);
        send_request(9'd1);
        write_total(9'd256);
        send_request(9'd255);
        send_request(9'd1);
        send_request(9'd1);

        // Random phases, each on a fresh table; small sizes drive it to full
        sent  = 0;
        phase = 0;
        while (sent < NUM_RANDOM) begin
            write_total(pick_total(phase));
            run_len = $urandom_range(60, 25);
            for (int i = 0; i < run_len && sent < NUM_RANDOM; i++) begin
                calm = (sent >= 300 && sent < 420);
                send_request(pick_size());
                sent++;
            end
            phase++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (100) @(posedge aclk);
        if (table_mirror.errors == 0 && table_mirror.pending() == 0) begin
            $display("PASS best_fit_segment_allocator");
        end else begin
            $display("FAIL best_fit_segment_allocator");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bfsa_pkg.sv
hdl/bfsa_ctrl.sv
hdl/bfsa_dp.sv
hdl/best_fit_segment_allocator.sv
sim/tb_best_fit_segment_allocator.sv
